FILE: design/gzmd_pkg.sv
// shared types, constants and helpers of the gzip member deframer
package gzmd_pkg;

    // gzip header constants
    localparam logic [7:0] ID1_VAL      = 8'd31;
    localparam logic [7:0] ID2_VAL      = 8'd139;
    localparam logic [7:0] CM_DEFLATE   = 8'd8;
    localparam logic [7:0] FLG_RESERVED = 8'he0;
    localparam logic [4:0] FLG_HCRC     = 5'(1 << 1);
    localparam logic [4:0] FLG_EXTRA    = 5'(1 << 2);
    localparam logic [4:0] FLG_NAME     = 5'(1 << 3);
    localparam logic [4:0] FLG_COMMENT  = 5'(1 << 4);

    // minimum file length, delay line size and fixed header part lengths
    localparam int MIN_FILE   = 18;
    localparam int TAIL_DEPTH = 8;
    localparam int FILL_W     = $clog2(TAIL_DEPTH + 1);
    localparam logic [15:0] FIXED_LEN = 16'd6;
    localparam logic [15:0] HCRC_LEN  = 16'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_CORRUPT     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // optional header part to start searching from
    localparam logic [1:0] STG_EXTRA   = 2'd0;
    localparam logic [1:0] STG_NAME    = 2'd1;
    localparam logic [1:0] STG_COMMENT = 2'd2;
    localparam logic [1:0] STG_HCRC    = 2'd3;

    // header parse phases
    typedef enum logic [3:0] {
        PH_ID1,
        PH_ID2,
        PH_CM,
        PH_FLG,
        PH_FIXED,
        PH_XLEN0,
        PH_XLEN1,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_HCRC,
        PH_DATA,
        PH_REJECT
    } t_phase;

    // one queued job: an optional payload byte and an optional report
    typedef struct packed {
        logic        has_pay;
        logic [7:0]  pay;
        logic        has_rep;
        logic [1:0]  status;
        logic [31:0] crc;
        logic [31:0] size;
    } t_entry;

    // next optional header part selected by the flags
    function automatic t_phase f_stage(input logic [1:0] stage, input logic [4:0] flags);
        t_phase ph;
        priority if (stage <= STG_EXTRA && (flags & FLG_EXTRA) != 5'd0) begin
            ph = PH_XLEN0;
        end else if (stage <= STG_NAME && (flags & FLG_NAME) != 5'd0) begin
            ph = PH_NAME;
        end else if (stage <= STG_COMMENT && (flags & FLG_COMMENT) != 5'd0) begin
            ph = PH_COMMENT;
        end else if ((flags & FLG_HCRC) != 5'd0) begin
            ph = PH_HCRC;
        end else begin
            ph = PH_DATA;
        end
        return ph;
    endfunction

endpackage

FILE: design/gzmd_front.sv
// front part: header parser, byte counter and footer delay line
module gzmd_front import gzmd_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_final,
    input  logic       i_q_full,
    output logic       o_push,
    output t_entry     o_entry
);

    t_phase                 r_phase, n_phase;
    logic [15:0]            r_count, n_count;
    logic [4:0]             r_flags, n_flags;
    logic [7:0]             r_xlen_low, n_xlen_low;
    logic [COUNT_WIDTH-1:0] r_bytes, n_bytes;
    logic                   r_id_bad, n_id_bad;
    logic                   r_unsup, n_unsup;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [7:0]             r_tail [TAIL_DEPTH];
    logic                   w_accept;
    logic                   w_emit;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_emit   = r_bytes >= COUNT_WIDTH'(TAIL_DEPTH) && r_fill >= FILL_W'(TAIL_DEPTH);
    assign o_push   = w_accept && (w_emit || i_final);

    // parse state update and job build
    always_comb begin
        logic [1:0]  v_status;
        logic [31:0] v_crc;
        logic [31:0] v_size;
        n_phase    = r_phase;
        n_count    = r_count;
        n_flags    = r_flags;
        n_xlen_low = r_xlen_low;
        n_bytes    = r_bytes;
        n_id_bad   = r_id_bad;
        n_unsup    = r_unsup;
        n_fill     = r_fill;
        v_status   = ST_OK;
        v_crc      = '0;
        v_size     = '0;
        if (w_accept) begin
            if (r_bytes != '1) begin
                n_bytes = r_bytes + COUNT_WIDTH'(1);
            end
            if (r_phase == PH_DATA) begin
                if (r_fill < FILL_W'(TAIL_DEPTH)) begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end else begin
                unique case (r_phase)
                    PH_ID1: begin
                        if (i_byte != ID1_VAL) begin
                            n_id_bad = 1'b1;
                            n_phase  = PH_REJECT;
                        end else begin
                            n_phase = PH_ID2;
                        end
                    end
                    PH_ID2: begin
                        if (i_byte != ID2_VAL) begin
                            n_id_bad = 1'b1;
                            n_phase  = PH_REJECT;
                        end else begin
                            n_phase = PH_CM;
                        end
                    end
                    PH_CM: begin
                        if (i_byte != CM_DEFLATE) begin
                            n_unsup = 1'b1;
                            n_phase = PH_REJECT;
                        end else begin
                            n_phase = PH_FLG;
                        end
                    end
                    PH_FLG: begin
                        if ((i_byte & FLG_RESERVED) != 8'd0) begin
                            n_unsup = 1'b1;
                            n_phase = PH_REJECT;
                        end else begin
                            n_flags = i_byte[4:0];
                            n_count = FIXED_LEN;
                            n_phase = PH_FIXED;
                        end
                    end
                    PH_FIXED, PH_EXTRA, PH_HCRC: begin
                        n_count = r_count - 16'd1;
                        if (n_count == 16'd0) begin
                            unique case (r_phase)
                                PH_FIXED: n_phase = f_stage(STG_EXTRA, r_flags);
                                PH_EXTRA: n_phase = f_stage(STG_NAME, r_flags);
                                default:  n_phase = PH_DATA;
                            endcase
                        end
                    end
                    PH_XLEN0: begin
                        n_xlen_low = i_byte;
                        n_phase    = PH_XLEN1;
                    end
                    PH_XLEN1: begin
                        n_count = {i_byte, r_xlen_low};
                        if (n_count == 16'd0) begin
                            n_phase = f_stage(STG_NAME, r_flags);
                        end else begin
                            n_phase = PH_EXTRA;
                        end
                    end
                    PH_NAME: begin
                        if (i_byte == 8'd0) begin
                            n_phase = f_stage(STG_COMMENT, r_flags);
                        end
                    end
                    PH_COMMENT: begin
                        if (i_byte == 8'd0) begin
                            n_phase = f_stage(STG_HCRC, r_flags);
                        end
                    end
                    default: begin
                    end
                endcase
                // header crc skip starts with its own length
                if (n_phase == PH_HCRC && r_phase != PH_HCRC) begin
                    n_count = HCRC_LEN;
                end
            end

            // end of file report
            if (i_final) begin
                priority if (n_bytes < COUNT_WIDTH'(MIN_FILE) || n_id_bad) begin
                    v_status = ST_CORRUPT;
                end else if (n_unsup) begin
                    v_status = ST_UNSUPPORTED;
                end else if (n_phase != PH_DATA || n_fill < FILL_W'(TAIL_DEPTH)) begin
                    v_status = ST_CORRUPT;
                end else begin
                    v_status = ST_OK;
                end
                if (n_bytes >= COUNT_WIDTH'(TAIL_DEPTH)) begin
                    v_crc  = {r_tail[4], r_tail[3], r_tail[2], r_tail[1]};
                    v_size = {i_byte, r_tail[7], r_tail[6], r_tail[5]};
                end
                n_phase    = PH_ID1;
                n_count    = '0;
                n_flags    = '0;
                n_xlen_low = '0;
                n_bytes    = '0;
                n_id_bad   = 1'b0;
                n_unsup    = 1'b0;
                n_fill     = '0;
            end
        end
        o_entry.has_pay = w_emit;
        o_entry.pay     = r_tail[0];
        o_entry.has_rep = i_final;
        o_entry.status  = v_status;
        o_entry.crc     = v_crc;
        o_entry.size    = v_size;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ID1;
            r_count    <= '0;
            r_flags    <= '0;
            r_xlen_low <= '0;
            r_bytes    <= '0;
            r_id_bad   <= 1'b0;
            r_unsup    <= 1'b0;
            r_fill     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_flags    <= n_flags;
            r_xlen_low <= n_xlen_low;
            r_bytes    <= n_bytes;
            r_id_bad   <= n_id_bad;
            r_unsup    <= n_unsup;
            r_fill     <= n_fill;
        end
    end

    // footer delay line
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < TAIL_DEPTH - 1; i++) begin
                r_tail[i] <= r_tail[i+1];
            end
            r_tail[TAIL_DEPTH-1] <= i_byte;
        end
    end

    // payload phase only after a clean id and method
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> !r_id_bad && !r_unsup)
        else $error("payload phase reached with a rejected header");

    // fill count never passes the line depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(TAIL_DEPTH))
        else $error("delay line fill count out of range");

endmodule

FILE: design/gzmd_queue.sv
// short job queue between the front and back parts
module gzmd_queue import gzmd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full job queue");

endmodule

FILE: design/gzmd_back.sv
// back part: turns queued jobs into result items in an output register
module gzmd_back import gzmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_entry      i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [79:0] o_data,
    output logic        o_last
);

    logic        r_valid, n_valid;
    logic        r_sub, n_sub;
    logic        r_kind, n_kind;
    logic [79:0] r_data, n_data;
    logic        r_last, n_last;
    logic        w_load;

    assign w_load  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;
    assign o_last  = r_last;

    // pick the next result from the head job
    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        n_kind  = r_kind;
        n_data  = r_data;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (w_load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (i_head.has_pay && !r_sub) begin
                    n_kind = KIND_PAYLOAD;
                    n_data = {72'd0, i_head.pay};
                    n_last = !i_head.has_rep;
                    n_sub  = i_head.has_rep;
                    o_pop  = !i_head.has_rep;
                end else begin
                    n_kind = KIND_REPORT;
                    n_data = {6'd0, i_head.size, i_head.crc, i_head.status, 8'd0};
                    n_last = 1'b1;
                    n_sub  = 1'b0;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_data <= n_data;
        r_last <= n_last;
    end

    // a half-sent job is still at the head and carries both parts
    a_sub_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> !i_empty && i_head.has_pay && i_head.has_rep)
        else $error("split job lost from queue head");

    // a report always closes the run of its item
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_REPORT |-> r_last)
        else $error("report item without end of run");

endmodule

FILE: design/gzip_member_deframer.sv
// top level of the gzip member deframer
//
//  port group   dir  tdata / tuser / tlast
//  s_axis       in   tdata[7:0] data byte, tlast final byte of file
//  m_axis       out  tdata payload/status/crc/size, tuser item kind, tlast end of run
//
//  one input item per cycle while the job queue is not full; a payload byte leaves
//  8 input items after it entered; the final byte of a file that also pushes out a
//  payload byte gives two results, the payload item first and then the report
//  a result passes from the job queue, written when its input byte is accepted,
//  to the output register
//  synchronous active-low reset clears the parser, counters, queue and output valid
//  a two-job queue lets the output stall without stopping input while it has room
module gzip_member_deframer import gzmd_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] status_code,
                                        // [41:10] footer_crc, [73:42] footer_size, zero pad
    output logic        m_axis_tuser,   // item_kind
    output logic        m_axis_tlast    // end_of_run
);

    logic   w_push, w_full, w_pop, w_empty;
    t_entry w_entry, w_head;

    // header parsing and delay line
    gzmd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    // job queue
    gzmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // result output
    gzmd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

FILE: dv/gzip_member_deframer_tb.sv
// self-checking testbench for the gzip member deframer: streams gzip files and checks every result
`timescale 1ns / 100ps

module gzip_member_deframer_tb;
    import gzmd_pkg::*;

    localparam int TARGET_BYTES = 1700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int END_WAIT     = 16;

    // one expected result of the block
    typedef struct packed {
        logic        kind;
        logic [7:0]  pay;
        logic [1:0]  status;
        logic [31:0] crc;
        logic [31:0] size;
        logic        eor;
    } t_result;

    // shapes of generated files
    typedef enum {
        FILE_GOOD,
        FILE_BAD_ID,
        FILE_BAD_CM,
        FILE_RESERVED,
        FILE_TRUNCATED,
        FILE_NOISE
    } t_file_kind;

    // receiver stall patterns
    typedef enum {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_BURSTY
    } t_rx_mode;

    // header parser, delay line and queue of expected results
    class deframe_checker;
        t_phase      phase;
        logic [15:0] countdown;
        logic [4:0]  flags;
        logic [7:0]  xlen_lo;
        logic [31:0] seen;
        logic        id_bad;
        logic        unsup;
        logic [7:0]  tail [TAIL_DEPTH];
        int          fill;
        t_result     expected_items [$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase     = PH_ID1;
            countdown = '0;
            flags     = '0;
            xlen_lo   = '0;
            seen      = '0;
            id_bad    = 1'b0;
            unsup     = 1'b0;
            fill      = 0;
            foreach (tail[i]) tail[i] = 8'd0;
        endfunction

        // pick the first optional header part present at or after the given one
        function void enter_part(int from);
            if (from <= 0 && (flags & FLG_EXTRA) != 5'd0) begin
                phase = PH_XLEN0;
            end else if (from <= 1 && (flags & FLG_NAME) != 5'd0) begin
                phase = PH_NAME;
            end else if (from <= 2 && (flags & FLG_COMMENT) != 5'd0) begin
                phase = PH_COMMENT;
            end else if ((flags & FLG_HCRC) != 5'd0) begin
                phase     = PH_HCRC;
                countdown = HCRC_LEN;
            end else begin
                phase = PH_DATA;
            end
        endfunction

        function void parse(logic [7:0] b);
            case (phase)
                PH_ID1: begin
                    if (b != ID1_VAL) begin
                        id_bad = 1'b1;
                        phase  = PH_REJECT;
                    end else begin
                        phase = PH_ID2;
                    end
                end
                PH_ID2: begin
                    if (b != ID2_VAL) begin
                        id_bad = 1'b1;
                        phase  = PH_REJECT;
                    end else begin
                        phase = PH_CM;
                    end
                end
                PH_CM: begin
                    if (b != CM_DEFLATE) begin
                        unsup = 1'b1;
                        phase = PH_REJECT;
                    end else begin
                        phase = PH_FLG;
                    end
                end
                PH_FLG: begin
                    if ((b & FLG_RESERVED) != 8'd0) begin
                        unsup = 1'b1;
                        phase = PH_REJECT;
                    end else begin
                        flags     = b[4:0];
                        countdown = FIXED_LEN;
                        phase     = PH_FIXED;
                    end
                end
                PH_FIXED: begin
                    countdown = countdown - 16'd1;
                    if (countdown == 16'd0) enter_part(0);
                end
                PH_XLEN0: begin
                    xlen_lo = b;
                    phase   = PH_XLEN1;
                end
                PH_XLEN1: begin
                    countdown = {b, xlen_lo};
                    if (countdown == 16'd0) enter_part(1);
                    else phase = PH_EXTRA;
                end
                PH_EXTRA: begin
                    countdown = countdown - 16'd1;
                    if (countdown == 16'd0) enter_part(1);
                end
                PH_NAME: begin
                    if (b == 8'd0) enter_part(2);
                end
                PH_COMMENT: begin
                    if (b == 8'd0) enter_part(3);
                end
                PH_HCRC: begin
                    countdown = countdown - 16'd1;
                    if (countdown == 16'd0) phase = PH_DATA;
                end
                default: begin
                end
            endcase
        endfunction

        // accepted input byte: shift the delay line and queue what it causes
        function void take_byte(logic [7:0] b, logic last);
            t_result    r;
            logic       was_data;
            logic       emit;
            logic [7:0] leaving;
            was_data = (phase == PH_DATA);
            emit     = (seen >= 32'd8) && (fill >= TAIL_DEPTH);
            leaving  = tail[0];
            for (int i = 0; i < TAIL_DEPTH - 1; i++) tail[i] = tail[i + 1];
            tail[TAIL_DEPTH - 1] = b;
            if (seen != '1) seen = seen + 32'd1;
            if (was_data) begin
                if (fill < TAIL_DEPTH) fill++;
            end else begin
                parse(b);
            end

            // payload byte pushed out of the delay line
            if (emit) begin
                r = '{kind: KIND_PAYLOAD, pay: leaving, status: ST_OK,
                      crc: 32'd0, size: 32'd0, eor: !last};
                expected_items.push_back(r);
            end

            // end-of-file report, then back to the start of a new file
            if (last) begin
                r = '{kind: KIND_REPORT, pay: 8'd0, status: ST_OK,
                      crc: 32'd0, size: 32'd0, eor: 1'b1};
                if (seen < MIN_FILE || id_bad) r.status = ST_CORRUPT;
                else if (unsup) r.status = ST_UNSUPPORTED;
                else if (phase != PH_DATA || fill < TAIL_DEPTH) r.status = ST_CORRUPT;
                if (seen >= 32'd8) begin
                    r.crc  = {tail[3], tail[2], tail[1], tail[0]};
                    r.size = {tail[7], tail[6], tail[5], tail[4]};
                end
                expected_items.push_back(r);
                clear();
            end
        endfunction

        function void mismatch(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10) $display("%s mismatch: expected %0h, got %0h", field, want, got);
        endfunction

        // accepted output item against the oldest expected result
        function void check_item(logic [79:0] d, logic kind, logic eor);
            t_result e;
            if (expected_items.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: tuser %0b tdata %0h", kind, d);
                return;
            end
            e = expected_items.pop_front();
            if (kind !== e.kind) mismatch("item kind", 32'(e.kind), 32'(kind));
            if (d[7:0] !== e.pay) mismatch("payload byte", 32'(e.pay), 32'(d[7:0]));
            if (d[9:8] !== e.status) mismatch("status", 32'(e.status), 32'(d[9:8]));
            if (d[41:10] !== e.crc) mismatch("footer crc", e.crc, d[41:10]);
            if (d[73:42] !== e.size) mismatch("footer size", e.size, d[73:42]);
            if (eor !== e.eor) mismatch("end of run", 32'(e.eor), 32'(eor));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;   // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // [7:0] payload_byte, [9:8] status_code,
                                        // [41:10] footer_crc, [73:42] footer_size, zero pad
    logic        m_axis_tuser;          // item_kind
    logic        m_axis_tlast;          // end_of_run

    deframe_checker sb;
    logic [7:0]     file_bytes [$];
    int             burst_left = 0;
    int             bytes_sent = 0;
    int             idle_cycles = 0;
    t_rx_mode       rx_mode = RX_OPEN;
    int             rx_mode_left = 0;
    int             rx_stall_left = 0;

    gzip_member_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitor both sides and watch for a stuck run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_item(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("gzip_member_deframer test failed");
                $finish;
            end
        end
    end

    // receiver ready, switching between stall patterns
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(50, 300);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN:  m_axis_tready = 1'b1;
            RX_LIGHT: m_axis_tready = ($urandom_range(0, 3) != 0);
            RX_HALF:  m_axis_tready = 1'($urandom_range(0, 1));
            default: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    m_axis_tready = 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_stall_left = $urandom_range(5, 24);
                    m_axis_tready = 1'b0;
                end else begin
                    m_axis_tready = 1'b1;
                end
            end
        endcase
    end

    // one input item, with burst gaps in front of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
    endtask

    // hold the sender until every expected result has come out
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.expected_items.size() != 0) @(negedge i_clk);
    endtask

    // random noise, or a well-formed member with random flags and content, then an optional defect
    task automatic build_file(input t_file_kind kind);
        logic [7:0]  flg;
        logic [7:0]  v;
        logic [15:0] xlen;
        int          n;
        file_bytes.delete();
        if (kind == FILE_NOISE) begin
            n = $urandom_range(1, 24);
            repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        flg = 8'($urandom_range(0, 31));
        file_bytes.push_back(ID1_VAL);
        file_bytes.push_back(ID2_VAL);
        file_bytes.push_back(CM_DEFLATE);
        file_bytes.push_back(flg);
        repeat (6) file_bytes.push_back(8'($urandom_range(0, 255)));
        if ((flg[4:0] & FLG_EXTRA) != 5'd0) begin
            xlen = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 700))
                                               : 16'($urandom_range(0, 5));
            file_bytes.push_back(xlen[7:0]);
            file_bytes.push_back(xlen[15:8]);
            repeat (xlen) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ((flg[4:0] & FLG_NAME) != 5'd0) begin
            repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom_range(1, 255)));
            file_bytes.push_back(8'd0);
        end
        if ((flg[4:0] & FLG_COMMENT) != 5'd0) begin
            repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom_range(1, 255)));
            file_bytes.push_back(8'd0);
        end
        if ((flg[4:0] & FLG_HCRC) != 5'd0) begin
            repeat (2) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 30)) file_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (8) file_bytes.push_back(8'($urandom_range(0, 255)));

        case (kind)
            FILE_BAD_ID: begin
                n = $urandom_range(0, 1);
                v = 8'($urandom_range(0, 255));
                if (v == file_bytes[n]) v = v ^ 8'h01;
                file_bytes[n] = v;
            end
            FILE_BAD_CM: begin
                v = 8'($urandom_range(0, 255));
                if (v == CM_DEFLATE) v = v ^ 8'h80;
                file_bytes[2] = v;
            end
            FILE_RESERVED: begin
                file_bytes[3] = file_bytes[3] | (8'h20 << $urandom_range(0, 2));
            end
            FILE_TRUNCATED: begin
                n = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > n) void'(file_bytes.pop_back());
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        int         r;
        t_file_kind kind;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // one-byte file, then a bad second id byte
        file_bytes = '{8'hff};
        send_file();
        file_bytes = '{ID1_VAL, 8'h00};
        send_file();
        // smallest complete file: bare header and footer, no payload
        file_bytes = '{ID1_VAL, ID2_VAL, CM_DEFLATE, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff,
                       8'h00, 8'hff, 8'hff, 8'h00, 8'h80, 8'h01, 8'hfe, 8'h7f, 8'h00, 8'hff};
        send_file();
        drain();

        // random files, mostly well-formed
        while (bytes_sent < TARGET_BYTES) begin
            r = $urandom_range(0, 19);
            if (r < 12) kind = FILE_GOOD;
            else if (r == 12) kind = FILE_BAD_ID;
            else if (r == 13) kind = FILE_BAD_CM;
            else if (r == 14) kind = FILE_RESERVED;
            else if (r < 18) kind = FILE_TRUNCATED;
            else kind = FILE_NOISE;
            build_file(kind);
            send_file();
            if ($urandom_range(0, 9) == 0) drain();
        end

        // let the last results come out
        drain();
        repeat (END_WAIT) @(negedge i_clk);
        if (sb.errors == 0 && sb.expected_items.size() == 0) begin
            $display("gzip_member_deframer test passed");
        end else begin
            $display("gzip_member_deframer test failed");
        end
        $finish;
    end

endmodule
